### hdl/lrukv_pkg.sv
// Shared constants for the LRU key-value cache.
// Field widths, operation codes and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

  // fixed field widths of the stream payloads and the config word
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int CFG_W   = 5;

  // operation codes carried on s_tuser
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // parameter defaults and register reset value
  localparam int          MAX_ENTRIES_DEF = 16;
  localparam int          VALUE_BITS_DEF  = 64;
  localparam logic [4:0]  CAPACITY_RESET  = 5'd16;

endpackage

`default_nettype wire

### hdl/lrukv_cell.sv
// One slot of the recency-ordered cell row: holds a key, a value and a valid bit.
// Compares its key to the lookup key and loads its neighbor's entry on shift.
// Depends on lrukv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrukv_cell #(
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        shift_en,
  input  wire logic                        kill,
  input  wire logic                        ld_valid,
  input  wire logic [lrukv_pkg::KEY_W-1:0] ld_key,
  input  wire logic [VALUE_BITS-1:0]       ld_value,
  input  wire logic [lrukv_pkg::KEY_W-1:0] cmp_key,
  output logic                             valid,
  output logic [lrukv_pkg::KEY_W-1:0]      key,
  output logic [VALUE_BITS-1:0]            value,
  output logic                             match
);

  // associative compare, gated by the valid bit
  assign match = valid && (key == cmp_key);

  // valid bit, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= ld_valid && !kill;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift_en) begin
      key   <= ld_key;
      value <= ld_value;
    end
  end

endmodule

`default_nettype wire

### hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Instantiates a row of lrukv_cell slots ordered by recency; depends on lrukv_pkg.
//
// Usage:
//   s_* channel carries one request per transaction: s_tuser is the operation
//   (get or put), s_tdata holds the key and the value to store.
//   m_* channel returns one result per request: m_tuser is the hit flag,
//   m_tdata the stored value on a get hit and zero otherwise.
//   cfg_wr_en / cfg_wr_data write the capacity in use; write only while idle.
// Result: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle while m_tready is high. All cells compare
//   the key in the accept cycle; the matching slot moves to the front of the row
//   (cell 0) while the cells ahead of it step back by one, so the row is always in
//   recency order. A put of a new key shifts the whole row and drops the oldest
//   entry when the count has reached the capacity.
// Reset clears all valid bits and the entry count and sets capacity to 16.
// Stall: the result register holds while m_tready is low; a new request is
//   taken only when that register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = lrukv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       cfg_wr_en,
  input  wire logic [lrukv_pkg::CFG_W-1:0]                cfg_wr_data,
  input  wire logic                                       s_tvalid,
  output logic                                            s_tready,
  // key [31:0], write_value [95:32]
  input  wire logic [lrukv_pkg::KEY_W+lrukv_pkg::VALUE_W-1:0] s_tdata,
  // operation [0]
  input  wire logic [0:0]                                 s_tuser,
  output logic                                            m_tvalid,
  input  wire logic                                       m_tready,
  // read_value [63:0]
  output logic [lrukv_pkg::VALUE_W-1:0]                   m_tdata,
  // hit [0]
  output logic [0:0]                                      m_tuser
);

  localparam int KEY_W = lrukv_pkg::KEY_W;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lrukv_pkg::CFG_W) ? CNT_W : lrukv_pkg::CFG_W;

  logic [lrukv_pkg::CFG_W-1:0] capacity;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;

  logic                    accept;
  logic                    is_put;
  logic [KEY_W-1:0]        in_key;
  logic [VALUE_BITS-1:0]   in_value;
  logic                    any_hit;
  logic                    evict;
  logic                    put_miss;
  logic [VALUE_BITS-1:0]   hit_value;

  logic [MAX_ENTRIES-1:0]  match;
  logic [MAX_ENTRIES-1:0]  shift_en;
  logic [MAX_ENTRIES-1:0]  kill;
  logic [MAX_ENTRIES-1:0]  cell_valid;
  logic [KEY_W-1:0]        cell_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]   cell_value [MAX_ENTRIES];

  // request unpacking
  assign accept   = s_tvalid && s_tready;
  assign is_put   = (s_tuser[0] == lrukv_pkg::OP_PUT);
  assign in_key   = s_tdata[KEY_W-1:0];
  assign in_value = s_tdata[KEY_W +: VALUE_BITS];

  // one result register parts the two sides
  assign s_tready = !m_tvalid || m_tready;

  // hit detection and selected value
  assign any_hit = |match;
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  // eviction when the count has reached the effective capacity
  always_comb begin
    if (count == CNT_W'(MAX_ENTRIES)) begin
      evict = 1'b1;
    end else if (capacity == '0) begin
      evict = (count != '0);
    end else begin
      evict = (CMP_W'(count) >= CMP_W'(capacity));
    end
  end

  assign put_miss   = accept && is_put && !any_hit;
  assign count_next = (put_miss && !evict) ? count + CNT_W'(1) : count;

  // per-cell shift and drop controls
  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_ctrl
      // a hit moves the cells up to and including the hit slot; a new put moves all
      assign shift_en[g] = accept && (any_hit ? (|(match >> g)) : is_put);
      // the entry pushed past the oldest valid slot is dropped on eviction
      assign kill[g]     = evict && (count == CNT_W'(g));
    end
  endgenerate

  // row of cells, cell 0 is the most recent
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        lrukv_cell #(
          .VALUE_BITS(VALUE_BITS)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (shift_en[g]),
          .kill     (kill[g]),
          .ld_valid (1'b1),
          .ld_key   (in_key),
          .ld_value (is_put ? in_value : hit_value),
          .cmp_key  (in_key),
          .valid    (cell_valid[g]),
          .key      (cell_key[g]),
          .value    (cell_value[g]),
          .match    (match[g])
        );
      end else begin : g_body
        lrukv_cell #(
          .VALUE_BITS(VALUE_BITS)
        ) u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (shift_en[g]),
          .kill     (kill[g]),
          .ld_valid (cell_valid[g-1]),
          .ld_key   (cell_key[g-1]),
          .ld_value (cell_value[g-1]),
          .cmp_key  (in_key),
          .valid    (cell_valid[g]),
          .key      (cell_key[g]),
          .value    (cell_value[g]),
          .match    (match[g])
        );
      end
    end
  endgenerate

  // capacity register and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrukv_pkg::CAPACITY_RESET;
      count    <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser[0] <= any_hit;
      m_tdata    <= (any_hit && !is_put) ? lrukv_pkg::VALUE_W'(hit_value) : '0;
    end
  end

endmodule

`default_nettype wire
